FILE: rtl/vrf_pkg.sv
// Shared types, constants and rounding helper for the vector rotation pipeline.
// No dependencies.
package vrf_pkg;

    localparam int NSTG = 7;

    typedef logic signed [31:0] t_word;
    typedef logic signed [15:0] t_ang_in;
    typedef logic signed [14:0] t_ang;
    typedef logic signed [16:0] t_trig;

    typedef struct packed {
        logic [1:0] rot;
        logic [3:0] sin;
        logic       wrap;
    } t_stage_en;

    localparam logic signed [16:0] ANG_PI      = 17'sd12868;
    localparam logic signed [16:0] ANG_TWO_PI  = 17'sd25736;
    localparam logic signed [16:0] ANG_HALF_PI = 17'sd6434;

    localparam logic signed [15:0] K_LIN = 16'sd20861;
    localparam logic [12:0]        K_SQR = 13'd6640;
    localparam logic signed [12:0] K_FIX = 13'sd3686;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // arithmetic right shift, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned n);
        logic signed [63:0] h;
        h = 64'sd1 <<< (n - 1);
        if (v < 0) begin
            h = h - 64'sd1;
        end
        return (v + h) >>> n;
    endfunction

endpackage

FILE: rtl/vrf_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on vrf_pkg.
interface vrf_in_if;
    import vrf_pkg::*;
    logic    valid;
    logic    ready;
    t_word   vec_x;
    t_word   vec_y;
    t_ang_in angle;
    modport source (output valid, vec_x, vec_y, angle, input ready);
    modport sink (input valid, vec_x, vec_y, angle, output ready);
endinterface

interface vrf_out_if;
    import vrf_pkg::*;
    logic  valid;
    logic  ready;
    t_word rot_x;
    t_word rot_y;
    modport source (output valid, rot_x, rot_y, input ready);
    modport sink (input valid, rot_x, rot_y, output ready);
endinterface

FILE: rtl/vrf_wrap.sv
// First stage: wraps the angle into -pi..pi and forms the cosine angle.
// Depends on vrf_pkg.
module vrf_wrap (
    input  logic             i_clk,
    input  logic             i_en,
    input  vrf_pkg::t_ang_in i_angle,
    input  vrf_pkg::t_word   i_x,
    input  vrf_pkg::t_word   i_y,
    output vrf_pkg::t_ang    o_ang,
    output vrf_pkg::t_ang    o_cang,
    output vrf_pkg::t_word   o_x,
    output vrf_pkg::t_word   o_y
);
    import vrf_pkg::*;

    logic signed [16:0] w0, w1, w2, w3, w4, c0, c1;
    t_ang  r_ang, r_cang;
    t_word r_x, r_y;

    always_comb begin
        w0 = 17'(i_angle);
        w1 = (w0 < -ANG_PI) ? w0 + ANG_TWO_PI : w0;
        w2 = (w1 < -ANG_PI) ? w1 + ANG_TWO_PI : w1;
        w3 = (w2 > ANG_PI) ? w2 - ANG_TWO_PI : w2;
        w4 = (w3 > ANG_PI) ? w3 - ANG_TWO_PI : w3;
        c0 = w4 + ANG_HALF_PI;
        c1 = (c0 > ANG_PI) ? c0 - ANG_TWO_PI : c0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang  <= w4[14:0];
            r_cang <= c1[14:0];
            r_x    <= i_x;
            r_y    <= i_y;
        end
    end

    assign o_ang  = r_ang;
    assign o_cang = r_cang;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

FILE: rtl/vrf_sin.sv
// Four-stage parabolic sine kernel with correction term, Q3.12 in, Q1.14 out.
// Depends on vrf_pkg.
module vrf_sin (
    input  logic          i_clk,
    input  logic [3:0]    i_en,
    input  vrf_pkg::t_ang i_ang,
    output vrf_pkg::t_trig o_val
);
    import vrf_pkg::*;

    logic signed [30:0] lin_p;
    logic signed [29:0] aa_p;
    logic signed [63:0] t1;
    logic signed [17:0] r_lin;
    logic [27:0]        r_aa;
    logic               r_neg;

    logic [40:0]        sq_p, sq_r;
    logic [16:0]        sqr;
    logic signed [18:0] s_w;
    t_trig              r_s;

    logic [16:0]        abs_s;
    logic signed [34:0] p;
    logic signed [63:0] t3;
    logic signed [21:0] d_w;
    logic signed [17:0] r_d;
    t_trig              r_s3;

    logic signed [30:0] m;
    logic signed [63:0] t4;
    logic signed [18:0] res;
    t_trig              r_out;

    always_comb begin
        lin_p = 31'(K_LIN) * 31'(i_ang);
        aa_p  = 30'(i_ang) * 30'(i_ang);
        t1    = rnd_shr(64'(lin_p), 12);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_lin <= t1[17:0];
            r_aa  <= aa_p[27:0];
            r_neg <= i_ang[14];
        end
    end

    always_comb begin
        sq_p = 41'(K_SQR) * 41'(r_aa);
        sq_r = sq_p + (41'd1 << 23);
        sqr  = sq_r[40:24];
        if (r_neg) begin
            s_w = 19'(r_lin) + $signed({2'b00, sqr});
        end else begin
            s_w = 19'(r_lin) - $signed({2'b00, sqr});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s <= s_w[16:0];
        end
    end

    always_comb begin
        abs_s = r_s[16] ? 17'(-r_s) : 17'(r_s);
        p     = 35'(r_s) * $signed({18'd0, abs_s});
        t3    = rnd_shr(64'(p), 14);
        d_w   = t3[21:0] - 22'(r_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_d  <= d_w[17:0];
            r_s3 <= r_s;
        end
    end

    always_comb begin
        m   = 31'(K_FIX) * 31'(r_d);
        t4  = rnd_shr(64'(m), 14);
        res = 19'(r_s3) + t4[18:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_out <= res[16:0];
        end
    end

    assign o_val = r_out;

endmodule

FILE: rtl/vrf_rot.sv
// Rotation stages: delays the vector alongside the sine kernels, forms the four
// products, then the rounded and saturated sums. Depends on vrf_pkg.
module vrf_rot (
    input  logic               i_clk,
    input  vrf_pkg::t_stage_en i_en,
    input  vrf_pkg::t_word     i_x,
    input  vrf_pkg::t_word     i_y,
    input  vrf_pkg::t_trig     i_sin,
    input  vrf_pkg::t_trig     i_cos,
    output vrf_pkg::t_word     o_rot_x,
    output vrf_pkg::t_word     o_rot_y
);
    import vrf_pkg::*;

    t_word r_xd [4];
    t_word r_yd [4];
    logic signed [48:0] r_xc, r_ys, r_xs, r_yc;
    logic signed [49:0] sum_x, sum_y;
    logic signed [63:0] t_x, t_y, s_x, s_y;
    t_word r_rot_x, r_rot_y;

    always_ff @(posedge i_clk) begin
        if (i_en.sin[0]) begin
            r_xd[0] <= i_x;
            r_yd[0] <= i_y;
        end
        for (int k = 1; k < 4; k++) begin
            if (i_en.sin[k]) begin
                r_xd[k] <= r_xd[k-1];
                r_yd[k] <= r_yd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rot[0]) begin
            r_xc <= 49'(r_xd[3]) * 49'(i_cos);
            r_ys <= 49'(r_yd[3]) * 49'(i_sin);
            r_xs <= 49'(r_xd[3]) * 49'(i_sin);
            r_yc <= 49'(r_yd[3]) * 49'(i_cos);
        end
    end

    always_comb begin
        sum_x = 50'(r_xc) - 50'(r_ys);
        sum_y = 50'(r_xs) + 50'(r_yc);
        t_x   = rnd_shr(64'(sum_x), 14);
        t_y   = rnd_shr(64'(sum_y), 14);
        s_x   = (t_x > SAT_MAX) ? SAT_MAX : ((t_x < SAT_MIN) ? SAT_MIN : t_x);
        s_y   = (t_y > SAT_MAX) ? SAT_MAX : ((t_y < SAT_MIN) ? SAT_MIN : t_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rot[1]) begin
            r_rot_x <= s_x[31:0];
            r_rot_y <= s_y[31:0];
        end
    end

    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;

endmodule

FILE: rtl/vector_rotate_fast_sincos.sv
// Top level: planar vector rotation by a Q3.12 angle with a fast sine/cosine.
// Depends on vrf_pkg, vrf_if, vrf_wrap, vrf_sin, vrf_rot.
//
//   channel   dir   payload                          handshake
//   i_in      in    vec_x, vec_y (Q16.16), angle     valid/ready
//   o_out     out   rot_x, rot_y (Q16.16, sat.)      valid/ready
//
// Seven register stages: angle wrap, four sine-kernel stages, product, sum/saturate.
// One item per cycle is accepted when the output is taken.
// Synchronous active-low reset clears only the stage valid bits.
// A stall holds each full stage; empty stages keep filling behind it.
module vector_rotate_fast_sincos (
    input  logic   i_clk,
    input  logic   i_rst_n,
    vrf_in_if.sink    i_in,
    vrf_out_if.source o_out
);
    import vrf_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    t_stage_en       en;
    t_ang            ang, cang;
    t_word           x0, y0;
    t_trig           sin_v, cos_v;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        en.wrap = rdy[0];
        en.sin  = rdy[4:1];
        en.rot  = rdy[6:5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    vrf_wrap u_wrap (
        .i_clk   (i_clk),
        .i_en    (en.wrap),
        .i_angle (i_in.angle),
        .i_x     (i_in.vec_x),
        .i_y     (i_in.vec_y),
        .o_ang   (ang),
        .o_cang  (cang),
        .o_x     (x0),
        .o_y     (y0)
    );

    vrf_sin u_sin (
        .i_clk (i_clk),
        .i_en  (en.sin),
        .i_ang (ang),
        .o_val (sin_v)
    );

    vrf_sin u_cos (
        .i_clk (i_clk),
        .i_en  (en.sin),
        .i_ang (cang),
        .o_val (cos_v)
    );

    vrf_rot u_rot (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (x0),
        .i_y     (y0),
        .i_sin   (sin_v),
        .i_cos   (cos_v),
        .o_rot_x (o_out.rot_x),
        .o_rot_y (o_out.rot_y)
    );

    assign i_in.ready  = rdy[0];
    assign o_out.valid = r_vld[NSTG-1];

endmodule

FILE: tb/vector_rotate_fast_sincos_tb.sv
// Self-checking bench for vector_rotate_fast_sincos: random valid/ready pacing on both
// channels, expected rotations computed in-bench from the fixed-point sine/cosine math.
// Depends on vrf_pkg, vrf_if and the vector_rotate_fast_sincos RTL.
module vector_rotate_fast_sincos_tb;
    import vrf_pkg::*;

    localparam longint PI_Q12      = 12868;
    localparam longint TWO_PI_Q12  = 25736;
    localparam longint HALF_PI_Q12 = 6434;
    localparam longint SIN_LIN_Q14 = 20861;
    localparam longint SIN_SQR_Q14 = 6640;
    localparam longint SIN_FIX_Q14 = 3686;
    localparam longint WORD_MAX    = 64'sd2147483647;
    localparam longint WORD_MIN    = -64'sd2147483648;
    localparam t_word  W_MAX       = 32'sh7fffffff;
    localparam t_word  W_MIN       = 32'sh80000000;
    localparam t_word  ONE_Q16     = 32'sh00010000;
    localparam int     MAX_WAIT    = 16;
    localparam int     N_RANDOM    = 600;

    typedef struct {
        t_word   x;
        t_word   y;
        t_ang_in ang;
        int      gap;
        bit      hold;
    } vec_item_t;

    typedef struct {
        t_word rx;
        t_word ry;
    } rot_res_t;

    logic i_clk;
    logic i_rst_n;

    vrf_in_if  in_if ();
    vrf_out_if out_if ();

    vector_rotate_fast_sincos uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    vec_item_t pend_q[$];
    rot_res_t  rot_q[$];
    int        accepted_cnt = 0;
    int        total_cnt    = 0;
    int        err_cnt      = 0;
    int        idle_cnt     = 0;
    int        stall_cnt    = 0;
    bit        calm_in      = 0;
    bit        calm_out     = 0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // round to nearest, ties away from zero
    function automatic longint rnd_shift(input longint v, input int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << (n - 1))) >> n;
        return (v < 0) ? -mag : mag;
    endfunction

    // a: Q3.12 within -pi..pi, result Q1.14
    function automatic longint fast_sin(input longint a);
        longint lin, sqr, s, q;
        lin = rnd_shift(SIN_LIN_Q14 * a, 12);
        sqr = rnd_shift(SIN_SQR_Q14 * (a * a), 24);
        s   = (a < 0) ? lin + sqr : lin - sqr;
        q   = rnd_shift(s * ((s < 0) ? -s : s), 14);
        return s + rnd_shift(SIN_FIX_Q14 * (q - s), 14);
    endfunction

    function automatic t_word sat_word(input longint v);
        if (v > WORD_MAX) return W_MAX;
        if (v < WORD_MIN) return W_MIN;
        return t_word'(v);
    endfunction

    function automatic rot_res_t rotate_vec(input t_word x, input t_word y, input t_ang_in ang);
        longint   a, ca, s, c, lx, ly;
        rot_res_t r;
        a = ang;
        while (a < -PI_Q12) a += TWO_PI_Q12;
        while (a > PI_Q12) a -= TWO_PI_Q12;
        ca = a + HALF_PI_Q12;
        if (ca > PI_Q12) ca -= TWO_PI_Q12;
        s = fast_sin(a);
        c = fast_sin(ca);
        lx = x;
        ly = y;
        r.rx = sat_word(rnd_shift(lx * c - ly * s, 14));
        r.ry = sat_word(rnd_shift(lx * s + ly * c, 14));
        return r;
    endfunction

    task automatic add_item(input t_word x, input t_word y, input t_ang_in ang, input bit hold);
        vec_item_t it;
        it.x    = x;
        it.y    = y;
        it.ang  = ang;
        it.gap  = calm_in ? 0 : $urandom_range(0, MAX_WAIT);
        it.hold = hold;
        pend_q.push_back(it);
        total_cnt++;
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
            1: begin
                case ($urandom_range(0, 4))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return ONE_Q16;
                endcase
            end
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_ang_in rand_angle();
        case ($urandom_range(0, 3))
            0: return t_ang_in'(($urandom_range(0, 1) ? PI_Q12 : -PI_Q12)
                                + $signed($urandom_range(0, 6)) - 3);
            1: return t_ang_in'($signed($urandom_range(0, 2 * PI_Q12)) - PI_Q12);
            default: return t_ang_in'($urandom);
        endcase
    endfunction

    task automatic report_err(input string what, input t_word want, input t_word got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR %s: expected %0d, got %0d at %0t", what, want, got, $time);
    endtask

    always @(posedge i_clk) begin : drv
        vec_item_t cur;
        logic      nxt_valid;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            idle_cnt = 0;
        end else begin
            nxt_valid = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                rot_q.push_back(rotate_vec(in_if.vec_x, in_if.vec_y, in_if.angle));
                accepted_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pend_q.size() != 0) begin
                if (pend_q[0].hold && rot_q.size() != 0) begin
                    idle_cnt = 0;
                end else if (idle_cnt < pend_q[0].gap) begin
                    idle_cnt++;
                end else begin
                    cur = pend_q.pop_front();
                    in_if.vec_x <= cur.x;
                    in_if.vec_y <= cur.y;
                    in_if.angle <= cur.ang;
                    nxt_valid = 1'b1;
                    idle_cnt = 0;
                end
            end
            in_if.valid <= nxt_valid;
        end
    end

    always @(posedge i_clk) begin : mon
        rot_res_t want;
        logic     nxt_ready;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            nxt_ready = out_if.ready;
            if (out_if.valid && out_if.ready) begin
                if (rot_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR unexpected result: rot_x %0d rot_y %0d at %0t",
                                 out_if.rot_x, out_if.rot_y, $time);
                end else begin
                    want = rot_q.pop_front();
                    if (out_if.rot_x !== want.rx) report_err("rot_x", want.rx, out_if.rot_x);
                    if (out_if.rot_y !== want.ry) report_err("rot_y", want.ry, out_if.rot_y);
                end
                if ($urandom_range(0, 31) == 0) calm_out = !calm_out;
                stall_cnt = calm_out ? 0 : $urandom_range(0, MAX_WAIT);
                nxt_ready = (stall_cnt == 0);
            end else if (!out_if.ready) begin
                if (stall_cnt > 0) stall_cnt--;
                nxt_ready = (stall_cnt == 0);
            end
            out_if.ready <= nxt_ready;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.vec_x  = '0;
        in_if.vec_y  = '0;
        in_if.angle  = '0;
        out_if.ready = 1'b0;

        // directed: field extremes, wrap cases, cosine shift, saturation
        add_item('0, '0, '0, 0);
        add_item(W_MAX, W_MIN, '0, 0);
        add_item(W_MIN, W_MAX, 16'sh8000, 0);
        add_item(W_MAX, W_MAX, 16'sh7fff, 0);
        add_item(ONE_Q16, '0, t_ang_in'(PI_Q12), 0);
        add_item(ONE_Q16, '0, t_ang_in'(-PI_Q12), 0);
        add_item(ONE_Q16, ONE_Q16, t_ang_in'(PI_Q12 + 1), 0);
        add_item(ONE_Q16, ONE_Q16, t_ang_in'(-PI_Q12 - 1), 0);
        add_item(ONE_Q16, '0, t_ang_in'(HALF_PI_Q12), 0);
        add_item('0, ONE_Q16, t_ang_in'(HALF_PI_Q12 + 1), 0);
        add_item(ONE_Q16, -ONE_Q16, t_ang_in'(-HALF_PI_Q12), 0);
        add_item(W_MAX, W_MAX, 16'sd3217, 0);
        add_item(W_MIN, W_MIN, 16'sd3217, 0);
        add_item(W_MIN, W_MIN, '0, 0);
        add_item(W_MAX, W_MIN, t_ang_in'(-HALF_PI_Q12), 0);
        add_item(-32'sd1, 32'sd1, 16'sd1, 0);
        add_item(32'sd1, -32'sd1, -16'sd1, 0);
        add_item(32'sh55555555, 32'shaaaaaaaa, 16'sh5555, 0);
        add_item(32'shaaaaaaaa, 32'sh55555555, 16'shaaaa, 0);
        add_item(W_MAX, W_MIN, t_ang_in'(TWO_PI_Q12), 0);
        add_item(W_MIN, W_MAX, t_ang_in'(-TWO_PI_Q12), 0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 29) == 0) calm_in = !calm_in;
            add_item(rand_word(), rand_word(), rand_angle(), (i == 300) || (i == 450));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_cnt || rot_q.size() != 0) @(posedge i_clk);
        repeat (4 * NSTG) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: vector_rotate_fast_sincos.f
rtl/vrf_pkg.sv
rtl/vrf_if.sv
rtl/vrf_wrap.sv
rtl/vrf_sin.sv
rtl/vrf_rot.sv
rtl/vector_rotate_fast_sincos.sv
tb/vector_rotate_fast_sincos_tb.sv
